>>> design/scl_pkg.sv
// Shared types, token kind codes and character classification for the script lexer.
// Used by scl_front, scl_back and script_lexer_tokenizer; depends on nothing else.
package scl_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 32;
  localparam int TEXT_BYTES = 32;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_EOL  = 2'd1;
  localparam logic [1:0] CMD_EOP  = 2'd2;

  localparam logic [5:0] K_FUNC    = 6'd0;
  localparam logic [5:0] K_VAR     = 6'd1;
  localparam logic [5:0] K_IF      = 6'd2;
  localparam logic [5:0] K_ELIF    = 6'd3;
  localparam logic [5:0] K_ELSE    = 6'd4;
  localparam logic [5:0] K_FOR     = 6'd5;
  localparam logic [5:0] K_TO      = 6'd6;
  localparam logic [5:0] K_STEP    = 6'd7;
  localparam logic [5:0] K_WHILE   = 6'd8;
  localparam logic [5:0] K_END     = 6'd9;
  localparam logic [5:0] K_BREAK   = 6'd10;
  localparam logic [5:0] K_RETURN  = 6'd11;
  localparam logic [5:0] K_PRINT   = 6'd12;
  localparam logic [5:0] K_PRINTLN = 6'd13;
  localparam logic [5:0] K_OPTION  = 6'd14;
  localparam logic [5:0] K_INPUT   = 6'd15;
  localparam logic [5:0] K_TOINT   = 6'd16;
  localparam logic [5:0] K_EXIT    = 6'd17;
  localparam logic [5:0] K_LPAREN  = 6'd18;
  localparam logic [5:0] K_RPAREN  = 6'd19;
  localparam logic [5:0] K_LBRACK  = 6'd20;
  localparam logic [5:0] K_RBRACK  = 6'd21;
  localparam logic [5:0] K_PLUS    = 6'd22;
  localparam logic [5:0] K_MINUS   = 6'd23;
  localparam logic [5:0] K_STAR    = 6'd24;
  localparam logic [5:0] K_SLASH   = 6'd25;
  localparam logic [5:0] K_EQEQ    = 6'd26;
  localparam logic [5:0] K_NE      = 6'd27;
  localparam logic [5:0] K_LT      = 6'd28;
  localparam logic [5:0] K_LE      = 6'd29;
  localparam logic [5:0] K_GT      = 6'd30;
  localparam logic [5:0] K_GE      = 6'd31;
  localparam logic [5:0] K_ANDAND  = 6'd32;
  localparam logic [5:0] K_OROR    = 6'd33;
  localparam logic [5:0] K_NOT     = 6'd34;
  localparam logic [5:0] K_PCT     = 6'd35;
  localparam logic [5:0] K_QUEST   = 6'd36;
  localparam logic [5:0] K_ASSIGN  = 6'd37;
  localparam logic [5:0] K_BSLASH  = 6'd38;
  localparam logic [5:0] K_COMMA   = 6'd39;
  localparam logic [5:0] K_IDENT   = 6'd40;
  localparam logic [5:0] K_INT     = 6'd41;
  localparam logic [5:0] K_DEC     = 6'd42;
  localparam logic [5:0] K_STR     = 6'd43;
  localparam logic [5:0] K_EOL     = 6'd44;
  localparam logic [5:0] K_EOP     = 6'd45;
  localparam logic [5:0] K_BAD     = 6'd46;
  localparam logic [5:0] K_OPEN    = 6'd47;
  localparam logic [5:0] K_LONG    = 6'd48;

  localparam logic [1:0] NUM_NONE = 2'd0;
  localparam logic [1:0] NUM_INT  = 2'd1;
  localparam logic [1:0] NUM_DEC  = 2'd2;

  typedef struct packed {
    logic [5:0]   kind;
    logic [255:0] text;
    logic [5:0]   len;
    logic [31:0]  int_part;
    logic [29:0]  frac_part;
    logic [3:0]   frac_digits;
    logic         last;
  } tok_t;

  typedef struct packed {
    tok_t t0;
    tok_t t1;
    logic two;
  } pair_t;

  typedef struct packed {
    logic  valid;
    pair_t pair;
  } push_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Characters that wait for the next one before their token is known.
  function automatic logic is_holdable(logic [7:0] c);
    return c == "+" || c == "-" || c == "<" || c == ">" || c == "=" ||
           c == "!" || c == "&" || c == "|" || c == "/";
  endfunction

  function automatic logic [5:0] op1_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "[":     k = K_LBRACK;
      "]":     k = K_RBRACK;
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "<":     k = K_LT;
      ">":     k = K_GT;
      "!":     k = K_NOT;
      "%":     k = K_PCT;
      "?":     k = K_QUEST;
      "=":     k = K_ASSIGN;
      8'h5c:   k = K_BSLASH;
      ",":     k = K_COMMA;
      default: k = K_BAD;
    endcase
    return k;
  endfunction

  function automatic logic is_pair(logic [7:0] h, logic [7:0] c);
    return (h == c && (h == "+" || h == "-" || h == "&" || h == "|" || h == "=")) ||
           (c == "=" && (h == "<" || h == ">" || h == "!"));
  endfunction

  function automatic logic [5:0] op2_kind(logic [7:0] h, logic [7:0] c);
    logic [5:0] k;
    case ({h, c})
      "==":    k = K_EQEQ;
      "!=":    k = K_NE;
      "<=":    k = K_LE;
      ">=":    k = K_GE;
      "&&":    k = K_ANDAND;
      "||":    k = K_OROR;
      default: k = K_BAD;
    endcase
    return k;
  endfunction

  // Bytes past the length are zero, so a length check plus a compare is exact.
  function automatic logic [5:0] kw_kind(logic [6:0][7:0] b, logic [5:0] len);
    logic [55:0] w;
    logic [5:0]  k;
    w = {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
    k = K_IDENT;
    case (len)
      6'd2: begin
        if (w[55:40] == "if") k = K_IF;
        if (w[55:40] == "to") k = K_TO;
      end
      6'd3: begin
        if (w[55:32] == "var") k = K_VAR;
        if (w[55:32] == "for") k = K_FOR;
        if (w[55:32] == "end") k = K_END;
      end
      6'd4: begin
        if (w[55:24] == "func") k = K_FUNC;
        if (w[55:24] == "elif") k = K_ELIF;
        if (w[55:24] == "else") k = K_ELSE;
        if (w[55:24] == "step") k = K_STEP;
        if (w[55:24] == "exit") k = K_EXIT;
      end
      6'd5: begin
        if (w[55:16] == "while") k = K_WHILE;
        if (w[55:16] == "break") k = K_BREAK;
        if (w[55:16] == "print") k = K_PRINT;
        if (w[55:16] == "input") k = K_INPUT;
        if (w[55:16] == "toint") k = K_TOINT;
      end
      6'd6: begin
        if (w[55:8] == "return") k = K_RETURN;
        if (w[55:8] == "option") k = K_OPTION;
      end
      6'd7: begin
        if (w == "println") k = K_PRINTLN;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  function automatic tok_t make_token(logic [5:0] k, logic txt, logic [1:0] num,
                                      logic [255:0] t, logic [5:0] len,
                                      logic [31:0] ia, logic [29:0] fa, logic [3:0] fc);
    tok_t r;
    r = '0;
    r.kind = k;
    if (txt) begin
      r.text = t;
      r.len = len;
    end
    if (num != NUM_NONE) r.int_part = ia;
    if (num == NUM_DEC) begin
      r.frac_part = fa;
      r.frac_digits = fc;
    end
    return r;
  endfunction

endpackage

>>> design/scl_front.sv
// Lexer front end: takes one input request, updates the lexer state and forms the
// up to two tokens it causes as one queue entry. Depends on scl_pkg.
module scl_front #(
  parameter int MAX_TOKEN_LEN = scl_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [1:0]        cmd,
  input  logic [7:0]        ch,
  output scl_pkg::push_t    push
);

  typedef enum logic [2:0] {M_IDLE, M_IDENT, M_INT, M_FRAC, M_STR, M_SKIP} mode_t;

  localparam logic [5:0] MaxLen = 6'(MAX_TOKEN_LEN);

  mode_t                   mode_r, mode_nxt;
  logic [MAX_TOKEN_LEN-1:0][7:0] text_r, text_nxt;
  logic [5:0]              cnt_r, cnt_nxt;
  logic [31:0]             ia_r, ia_nxt;
  logic [29:0]             fa_r, fa_nxt;
  logic [3:0]              fc_r, fc_nxt;
  logic [7:0]              hc_r, hc_nxt;
  logic                    hv_r, hv_nxt;

  logic [31:0][7:0]        tb_view;
  logic [31:0][7:0]        tb;
  mode_t                   m;
  logic [5:0]              cnt;
  logic [31:0]             ia;
  logic [29:0]             fa;
  logic [3:0]              fc;
  logic [7:0]              hc;
  logic                    hv;
  logic [1:0]              n;
  scl_pkg::tok_t           tk [2];
  logic                    done, handled;
  logic [5:0]              k;
  logic [35:0]             v;
  logic [3:0]              d;

  // Masked view of the store: bytes at or past the count read as zero.
  for (genvar i = 0; i < 32; i++) begin : g_view
    if (i < MAX_TOKEN_LEN) begin : g_in
      assign tb_view[i] = (6'(i) < cnt_r) ? text_r[i] : 8'h00;
      assign text_nxt[i] = tb[i];
    end else begin : g_out
      assign tb_view[i] = 8'h00;
    end
  end

  always_comb begin
    m = mode_r;
    cnt = cnt_r;
    tb = tb_view;
    ia = ia_r;
    fa = fa_r;
    fc = fc_r;
    hc = hc_r;
    hv = hv_r;
    n = 2'd0;
    tk[0] = '0;
    tk[1] = '0;
    done = 1'b0;
    handled = 1'b0;
    k = scl_pkg::K_BAD;
    d = ch[3:0];
    v = ({1'b0, ia_r, 3'b000}) + ({3'b000, ia_r, 1'b0}) + 36'(d);
    if (in_fire) begin
      case (cmd)
        scl_pkg::CMD_CHAR: begin
          done = (m == M_SKIP);
          if (!done && hv) begin
            hv = 1'b0;
            if (hc == "/" && ch == "/") begin
              if (m == M_STR) begin
                tk[n[0]] = scl_pkg::make_token(scl_pkg::K_OPEN, 1'b1, scl_pkg::NUM_NONE,
                                               tb, cnt, ia, fa, fc);
                n = n + 2'd1;
              end
              m = M_SKIP;
              done = 1'b1;
            end else if (m == M_STR) begin
              if (cnt < MaxLen) begin
                tb[cnt[4:0]] = "/";
                cnt = cnt + 6'd1;
              end else begin
                tk[n[0]] = scl_pkg::make_token(scl_pkg::K_LONG, 1'b1, scl_pkg::NUM_NONE,
                                               tb, cnt, ia, fa, fc);
                n = n + 2'd1;
                m = M_SKIP;
                done = 1'b1;
              end
            end else begin
              tb = '0;
              tb[0] = hc;
              cnt = 6'd1;
              if (scl_pkg::is_pair(hc, ch)) begin
                tb[1] = ch;
                cnt = 6'd2;
                k = scl_pkg::op2_kind(hc, ch);
                tk[n[0]] = scl_pkg::make_token(k, 1'b1, scl_pkg::NUM_NONE, tb, cnt, ia, fa, fc);
                n = n + 2'd1;
                if (k == scl_pkg::K_BAD) m = M_SKIP;
                done = 1'b1;
              end else begin
                k = scl_pkg::op1_kind(hc);
                tk[n[0]] = scl_pkg::make_token(k, 1'b1, scl_pkg::NUM_NONE, tb, cnt, ia, fa, fc);
                n = n + 2'd1;
                if (k == scl_pkg::K_BAD) begin
                  m = M_SKIP;
                  done = 1'b1;
                end
              end
            end
          end
          if (!done) begin
            case (m)
              M_STR: begin
                handled = 1'b1;
                if (ch == "\"") begin
                  tk[n[0]] = scl_pkg::make_token(scl_pkg::K_STR, 1'b1, scl_pkg::NUM_NONE,
                                                 tb, cnt, ia, fa, fc);
                  n = n + 2'd1;
                  m = M_IDLE;
                end else if (ch == "/") begin
                  hc = ch;
                  hv = 1'b1;
                end else if (cnt < MaxLen) begin
                  tb[cnt[4:0]] = ch;
                  cnt = cnt + 6'd1;
                end else begin
                  tk[n[0]] = scl_pkg::make_token(scl_pkg::K_LONG, 1'b1, scl_pkg::NUM_NONE,
                                                 tb, cnt, ia, fa, fc);
                  n = n + 2'd1;
                  m = M_SKIP;
                end
              end
              M_IDENT, M_INT, M_FRAC: begin
                if (scl_pkg::is_digit(ch) || (m == M_IDENT && scl_pkg::is_letter(ch)) ||
                    (m == M_INT && ch == ".")) begin
                  handled = 1'b1;
                  if (cnt < MaxLen) begin
                    tb[cnt[4:0]] = ch;
                    cnt = cnt + 6'd1;
                    if (m == M_INT && ch == ".") begin
                      m = M_FRAC;
                    end else if (m == M_INT) begin
                      ia = (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
                    end else if (m == M_FRAC && fc < 4'd9) begin
                      fa = 30'(({3'b000, fa} << 3) + ({3'b000, fa} << 1) + 33'(d));
                      fc = fc + 4'd1;
                    end
                  end else begin
                    tk[n[0]] = scl_pkg::make_token(scl_pkg::K_LONG, 1'b1, scl_pkg::NUM_NONE,
                                                   tb, cnt, ia, fa, fc);
                    n = n + 2'd1;
                    m = M_SKIP;
                  end
                end
              end
              default: handled = 1'b0;
            endcase
            if (!handled) begin
              // The current word ends here.
              if (m == M_IDENT) begin
                tk[n[0]] = scl_pkg::make_token(scl_pkg::kw_kind(tb[6:0], cnt), 1'b1,
                                               scl_pkg::NUM_NONE, tb, cnt, ia, fa, fc);
                n = n + 2'd1;
              end else if (m == M_INT) begin
                tk[n[0]] = scl_pkg::make_token(scl_pkg::K_INT, 1'b1, scl_pkg::NUM_INT,
                                               tb, cnt, ia, fa, fc);
                n = n + 2'd1;
              end else if (m == M_FRAC) begin
                tk[n[0]] = scl_pkg::make_token(scl_pkg::K_DEC, 1'b1, scl_pkg::NUM_DEC,
                                               tb, cnt, ia, fa, fc);
                n = n + 2'd1;
              end
              m = M_IDLE;
              // The character then starts something new.
              if (ch != " " && ch != "\t") begin
                tb = '0;
                cnt = 6'd0;
                ia = '0;
                fa = '0;
                fc = '0;
                if (scl_pkg::is_letter(ch) || ch == "$") begin
                  tb[0] = ch;
                  cnt = 6'd1;
                  m = M_IDENT;
                end else if (scl_pkg::is_digit(ch)) begin
                  tb[0] = ch;
                  cnt = 6'd1;
                  ia = 32'(d);
                  m = M_INT;
                end else if (ch == "\"") begin
                  m = M_STR;
                end else if (scl_pkg::is_holdable(ch)) begin
                  hc = ch;
                  hv = 1'b1;
                end else begin
                  tb[0] = ch;
                  cnt = 6'd1;
                  k = scl_pkg::op1_kind(ch);
                  tk[n[0]] = scl_pkg::make_token(k, 1'b1, scl_pkg::NUM_NONE,
                                                 tb, cnt, ia, fa, fc);
                  n = n + 2'd1;
                  if (k == scl_pkg::K_BAD) m = M_SKIP;
                end
              end
            end
          end
        end
        scl_pkg::CMD_EOL, scl_pkg::CMD_EOP: begin
          if (hv && m != M_STR) begin
            tb = '0;
            tb[0] = hc;
            cnt = 6'd1;
            tk[n[0]] = scl_pkg::make_token(scl_pkg::op1_kind(hc), 1'b1, scl_pkg::NUM_NONE,
                                           tb, cnt, ia, fa, fc);
            n = n + 2'd1;
          end else if (m == M_STR) begin
            tk[n[0]] = scl_pkg::make_token(scl_pkg::K_OPEN, 1'b1, scl_pkg::NUM_NONE,
                                           tb, cnt, ia, fa, fc);
            n = n + 2'd1;
          end else if (m == M_IDENT) begin
            tk[n[0]] = scl_pkg::make_token(scl_pkg::kw_kind(tb[6:0], cnt), 1'b1,
                                           scl_pkg::NUM_NONE, tb, cnt, ia, fa, fc);
            n = n + 2'd1;
          end else if (m == M_INT) begin
            tk[n[0]] = scl_pkg::make_token(scl_pkg::K_INT, 1'b1, scl_pkg::NUM_INT,
                                           tb, cnt, ia, fa, fc);
            n = n + 2'd1;
          end else if (m == M_FRAC) begin
            tk[n[0]] = scl_pkg::make_token(scl_pkg::K_DEC, 1'b1, scl_pkg::NUM_DEC,
                                           tb, cnt, ia, fa, fc);
            n = n + 2'd1;
          end
          tk[n[0]] = scl_pkg::make_token((cmd == scl_pkg::CMD_EOL) ? scl_pkg::K_EOL :
                                         scl_pkg::K_EOP, 1'b0, scl_pkg::NUM_NONE,
                                         tb, cnt, ia, fa, fc);
          n = n + 2'd1;
          cnt = 6'd0;
          ia = '0;
          fa = '0;
          fc = '0;
          hc = 8'h00;
          hv = 1'b0;
          m = M_IDLE;
        end
        default: done = 1'b1;
      endcase
    end
    if (n == 2'd1) tk[0].last = 1'b1;
    if (n == 2'd2) tk[1].last = 1'b1;
    mode_nxt = m;
    cnt_nxt = cnt;
    ia_nxt = ia;
    fa_nxt = fa;
    fc_nxt = fc;
    hc_nxt = hc;
    hv_nxt = hv;
  end

  assign push.valid = in_fire && (n != 2'd0);
  assign push.pair.t0 = tk[0];
  assign push.pair.t1 = tk[1];
  assign push.pair.two = (n == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      cnt_r <= '0;
      ia_r <= '0;
      fa_r <= '0;
      fc_r <= '0;
      hc_r <= '0;
      hv_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r <= cnt_nxt;
      ia_r <= ia_nxt;
      fa_r <= fa_nxt;
      fc_r <= fc_nxt;
      hc_r <= hc_nxt;
      hv_r <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    text_r <= text_nxt;
  end

  // A held character only waits between tokens or inside a string.
  assert property (@(posedge clk) disable iff (!rst_n)
    hv_r |-> (mode_r == M_IDLE || mode_r == M_STR))
    else $error("held character outside idle or string mode");

  // End of line or program always leaves the lexer idle and empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (cmd == scl_pkg::CMD_EOL || cmd == scl_pkg::CMD_EOP)
    |=> mode_r == M_IDLE && cnt_r == 6'd0 && !hv_r)
    else $error("lexer not cleared after end of line or program");

  // The stored length never passes the token limit.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MaxLen)
    else $error("token length beyond limit");

endmodule

>>> design/scl_back.sv
// Lexer back end: a short queue of token pairs and the output register that
// hands tokens out one at a time. Depends on scl_pkg.
module scl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  scl_pkg::push_t  push,
  output logic            q_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output scl_pkg::tok_t   out_tok
);

  scl_pkg::pair_t             q_r [scl_pkg::Q_DEPTH];
  logic [scl_pkg::Q_AW-1:0]   wp_r, rp_r;
  logic [scl_pkg::Q_AW:0]     cnt_r, cnt_nxt;
  logic                       sel_r;
  logic                       ov_r;
  scl_pkg::tok_t              tok_r;
  scl_pkg::pair_t             head;
  logic                       load, pop;

  assign head = q_r[rp_r];
  assign load = (cnt_r != '0) && (!ov_r || out_ready);
  assign pop = load && (sel_r || !head.two);
  assign q_ready = (cnt_r != (scl_pkg::Q_AW + 1)'(scl_pkg::Q_DEPTH));
  assign cnt_nxt = cnt_r + {{scl_pkg::Q_AW{1'b0}}, push.valid} - {{scl_pkg::Q_AW{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (push.valid) q_r[wp_r] <= push.pair;
    if (load) tok_r <= sel_r ? head.t1 : head.t0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      sel_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (load) begin
        ov_r <= 1'b1;
        sel_r <= !pop;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_tok = tok_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (scl_pkg::Q_AW + 1)'(scl_pkg::Q_DEPTH))
    else $error("token queue overfilled");

  assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> q_ready)
    else $error("push into full token queue");

  // The second token of a pair is pending only while its entry is still queued.
  assert property (@(posedge clk) disable iff (!rst_n) sel_r |-> cnt_r != '0)
    else $error("second token selected with empty queue");

endmodule

>>> design/script_lexer_tokenizer.sv
// Top level of the streaming script lexer: stream ports, front end and back end.
// Depends on scl_pkg, scl_front and scl_back.
//
// The lexer takes one request per cycle while the queue is not full: a character,
// an end of line or an end of program, with the command in in_tuser and the byte
// in in_tdata. Each request gives zero, one or two tokens. The front end decides
// all tokens of a request in the cycle it is accepted and writes them as one entry
// into a two-entry queue; the back end sends them out one per cycle, while the
// output is not stalled, through an output register, so a token passes the queue
// and then the output register before it is presented on the output port. The
// entry of a request leaves the queue when its last token is loaded into the
// output register, and a new request can be taken while earlier tokens wait.
// in_tready drops only while the queue is full. Operator characters that may
// pair with the next one, and a slash that may open a comment, are held and come
// out with the following request. Integer values saturate at the top of their
// range, fractions keep at most nine digits, and the text of a token holds at
// most MAX_TOKEN_LEN bytes; longer tokens give an overlong error.
module script_lexer_tokenizer #(
  parameter int MAX_TOKEN_LEN = scl_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // char_code
  input  logic [1:0]   in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [327:0] out_tdata,  // text_bytes_0_7, text_bytes_8_15, text_bytes_16_23,
                                   // text_bytes_24_31, text_length, int_part,
                                   // frac_part, frac_digits
  output logic [5:0]   out_tuser,  // token_kind
  output logic         out_tlast   // last token of a request
);

  scl_pkg::push_t push;
  scl_pkg::tok_t  tok;
  logic           in_fire;

  // A request is taken only when the queue can hold all tokens it may cause.
  assign in_fire = in_tvalid && in_tready;

  scl_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .cmd     (in_tuser),
    .ch      (in_tdata),
    .push    (push)
  );

  scl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_ready   (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (tok)
  );

  // Fields are packed from the lowest bit up in the order listed beside the port.
  assign out_tdata = {tok.frac_digits, tok.frac_part, tok.int_part, tok.len, tok.text};
  assign out_tuser = tok.kind;
  assign out_tlast = tok.last;

endmodule
